FILE: rtl/cwif_pkg.sv
// ----------------------------------------------------------------------------
// cwif_pkg
// Shared constants, types and helpers of the cross-window impulse filter.
// ----------------------------------------------------------------------------
package cwif_pkg;

  localparam int MAX_WIDTH     = 4096;
  localparam int CHANNEL_BITS  = 8;
  localparam int CHANNELS      = 3;
  localparam int TAPS          = 3;
  localparam int PIXEL_BITS    = CHANNELS * CHANNEL_BITS;

  localparam int CFG_DIM_BITS  = 13;
  localparam int ANCHOR_BITS   = 2;
  localparam int LIMIT_BITS    = 9;

  localparam int W_BITS        = $clog2(MAX_WIDTH + 1);
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int ROW_BITS      = CFG_DIM_BITS;
  localparam int SLOTS         = 2 * MAX_WIDTH + 4;
  localparam int ADDR_BITS     = $clog2(SLOTS);
  localparam int LAG_BITS      = ADDR_BITS;
  localparam int OFF_BITS      = ADDR_BITS + 2;

  localparam int TAP_READS     = 5;
  localparam int K_BITS        = $clog2(TAP_READS);
  localparam int CNT_BITS      = $clog2(TAP_READS + 1);
  localparam int SUM_BITS      = CHANNEL_BITS + 3;
  localparam int RECIP_SHIFT   = 16;
  localparam int RECIP_BITS    = RECIP_SHIFT + 1;
  localparam int PROD_BITS     = SUM_BITS + RECIP_BITS;

  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

  localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_ANCHOR_X      = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_ANCHOR_Y      = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_REPLACE_LIMIT = 3'd4;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic clear;
    logic tap_en;
    logic is_centre;
    logic mul_en;
  } lane_ctrl_t;

  // Reciprocal of the tap count, scaled by 2^RECIP_SHIFT and rounded up;
  // exact truncated quotient for every sum a lane can hold.
  function automatic logic [RECIP_BITS-1:0] recip_of(input logic [CNT_BITS-1:0] cnt);
    logic [RECIP_BITS-1:0] r;
    unique case (cnt)
      3'd2:    r = 17'd32768;
      3'd3:    r = 17'd21846;
      3'd4:    r = 17'd16384;
      3'd5:    r = 17'd13108;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/cwif_in_if.sv
// ----------------------------------------------------------------------------
// cwif_in_if
// Input channel: one pixel or drain command per item.
// ----------------------------------------------------------------------------
interface cwif_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [cwif_pkg::PIXEL_BITS-1:0]     pixel_rgb;

  modport source (output valid, output command, output pixel_rgb, input ready);
  modport sink   (input valid, input command, input pixel_rgb, output ready);
  modport mon    (input valid, input command, input pixel_rgb, input ready);
endinterface

FILE: rtl/cwif_out_if.sv
// ----------------------------------------------------------------------------
// cwif_out_if
// Output channel: one filtered pixel per item.
// ----------------------------------------------------------------------------
interface cwif_out_if;
  logic                                valid;
  logic                                ready;
  logic [cwif_pkg::PIXEL_BITS-1:0]     filtered_rgb;
  logic                                end_of_frame;

  modport source (output valid, output filtered_rgb, output end_of_frame, input ready);
  modport sink   (input valid, input filtered_rgb, input end_of_frame, output ready);
  modport mon    (input valid, input filtered_rgb, input end_of_frame, input ready);
endinterface

FILE: rtl/cwif_lane.sv
// ----------------------------------------------------------------------------
// cwif_lane
// One color channel: accumulate taps, form the mean, replace impulses.
// ----------------------------------------------------------------------------
module cwif_lane (
  input  logic                                      clk,
  input  cwif_pkg::lane_ctrl_t                      ctrl,
  input  logic [cwif_pkg::CHANNEL_BITS-1:0]         tap,
  input  logic [cwif_pkg::RECIP_BITS-1:0]           recip,
  input  logic signed [cwif_pkg::LIMIT_BITS-1:0]    limit,
  output logic [cwif_pkg::CHANNEL_BITS-1:0]         result
);
  import cwif_pkg::*;

  logic [SUM_BITS-1:0]           sum;
  logic [CHANNEL_BITS-1:0]       centre;
  logic [PROD_BITS-1:0]          prod;
  logic [CHANNEL_BITS-1:0]       mean;
  logic signed [CHANNEL_BITS+1:0] diff;
  logic signed [CHANNEL_BITS+1:0] lim_ext;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum <= '0;
    end else if (ctrl.tap_en) begin
      sum <= sum + SUM_BITS'(tap);
    end
    if (ctrl.tap_en && ctrl.is_centre) begin
      centre <= tap;
    end
    if (ctrl.mul_en) begin
      prod <= PROD_BITS'(sum) * PROD_BITS'(recip);
    end
  end

  // mean never exceeds the channel range
  always_comb begin
    mean    = prod[RECIP_SHIFT +: CHANNEL_BITS];
    diff    = $signed({2'b00, centre}) - $signed({2'b00, mean});
    lim_ext = (CHANNEL_BITS+2)'(limit);
    result  = (diff > lim_ext) ? mean : centre;
  end

endmodule

FILE: rtl/cross_window_impulse_filter.sv
// ----------------------------------------------------------------------------
// cross_window_impulse_filter
// Thresholded-mean impulse filter over a 3+3 cross window on RGB pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and are kept in a circular store of
// 2*MAX_WIDTH+4 entries with a single read port. A pixel that completes the
// window of an earlier pixel triggers that pixel's output: the five window
// taps are read one per cycle, three channel lanes accumulate them, each lane
// multiplies its sum by the reciprocal of the tap count and replaces the pixel
// by the mean where it stands above the mean by more than replace_limit.
// An item that releases an output occupies the block through accept, five tap
// reads through the store's read port, final accumulate, multiply and output
// load; an item that releases nothing leaves the block ready. The output
// register lets the next item enter while a result waits. Drain commands
// after the last pixel flush the remaining rows; a pixel offered after frame
// end is taken as a drain step and dropped. Any register write restarts the
// frame; write registers only while the block is idle.
// ----------------------------------------------------------------------------
module cross_window_impulse_filter (
  input  logic                                  clk,
  input  logic                                  rst,
  cwif_in_if.sink                               pixel_stream,
  cwif_out_if.source                            filtered_stream,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [cwif_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [cwif_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [cwif_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                  pready
);
  import cwif_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_LAST, S_MUL, S_OUT} state_t;

  // configuration
  logic [CFG_DIM_BITS-1:0]      image_width;
  logic [CFG_DIM_BITS-1:0]      image_height;
  logic [ANCHOR_BITS-1:0]       anchor_x;
  logic [ANCHOR_BITS-1:0]       anchor_y;
  logic signed [LIMIT_BITS-1:0] replace_limit;

  // sequencer and raster positions
  state_t                  state;
  logic [ROW_BITS-1:0]     in_row, out_row;
  logic [COL_BITS-1:0]     in_col, out_col;
  logic [ADDR_BITS-1:0]    wa, oa;
  logic [LAG_BITS-1:0]     lag;
  logic [K_BITS-1:0]       k, rd_k;
  logic                    rd_v;
  logic [TAP_READS-1:0]    mask;
  logic [RECIP_BITS-1:0]   recip;

  // pixel store
  logic [PIXEL_BITS-1:0]   store [SLOTS];
  logic [PIXEL_BITS-1:0]   rdata;

  // output register
  logic                    out_valid;
  logic [PIXEL_BITS-1:0]   out_rgb;
  logic                    out_eof;

  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    cfg_wr;
  logic [W_BITS-1:0]       w_eff;
  logic [ROW_BITS-1:0]     h_eff;
  logic [1:0]              cx, cy;
  logic                    accept, in_frame, out_open, wr_en, emit, last_out, out_free;
  logic [LAG_BITS-1:0]     delay;
  logic [TAP_READS-1:0]    mask_now;
  logic [CNT_BITS-1:0]     count_now;
  logic [1:0]              h0, h1;
  logic signed [OFF_BITS-1:0] w_s, off, raw;
  logic signed [3:0]       dv, dh;
  logic [ADDR_BITS-1:0]    rd_addr;
  lane_ctrl_t              lane_ctrl;
  logic [PIXEL_BITS-1:0]   lane_res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_IMAGE_WIDTH:   prdata = APB_DATA_BITS'(image_width);
      REG_IMAGE_HEIGHT:  prdata = APB_DATA_BITS'(image_height);
      REG_ANCHOR_X:      prdata = APB_DATA_BITS'(anchor_x);
      REG_ANCHOR_Y:      prdata = APB_DATA_BITS'(anchor_y);
      REG_REPLACE_LIMIT: prdata = APB_DATA_BITS'(replace_limit);
      default:           prdata = '0;
    endcase
  end

  // Effective geometry: clamp width, treat zero sizes as one, anchor three as two.
  always_comb begin
    if (image_width == '0) begin
      w_eff = W_BITS'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = W_BITS'(MAX_WIDTH);
    end else begin
      w_eff = W_BITS'(image_width);
    end
    h_eff = (image_height == '0) ? ROW_BITS'(1) : image_height;
    cx    = (anchor_x == 2'd3) ? 2'd2 : anchor_x;
    cy    = (anchor_y == 2'd3) ? 2'd2 : anchor_y;
  end

  // Window completes (2-cy) rows later, or 2-cx pixels later with the anchor on
  // the bottom row.
  always_comb begin
    if (cy == 2'd0) begin
      delay = LAG_BITS'(w_eff) << 1;
    end else if (cy == 2'd1) begin
      delay = LAG_BITS'(w_eff);
    end else begin
      delay = LAG_BITS'(2'd2 - cx);
    end
  end

  assign pixel_stream.ready = (state == S_IDLE);
  assign accept   = pixel_stream.valid && pixel_stream.ready;
  assign in_frame = in_row < h_eff;
  assign out_open = out_row < h_eff;
  assign wr_en    = accept && in_frame && (pixel_stream.command == CMD_PIXEL);
  assign emit     = (wr_en && (lag >= delay)) || (accept && !in_frame && out_open);
  assign last_out = (out_row == h_eff - ROW_BITS'(1)) &&
                    (W_BITS'(out_col) == w_eff - W_BITS'(1));
  assign out_free = !out_valid || filtered_stream.ready;

  // Horizontal taps other than the anchor.
  assign h0 = (cx == 2'd0) ? 2'd1 : 2'd0;
  assign h1 = (cx == 2'd2) ? 2'd1 : 2'd2;

  // In-image taps of the pending output pixel; the anchor is always in.
  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      mask_now[t] = ((ROW_BITS+2)'(out_row) + (ROW_BITS+2)'(t) >= (ROW_BITS+2)'(cy)) &&
                    ((ROW_BITS+2)'(out_row) + (ROW_BITS+2)'(t) <
                     (ROW_BITS+2)'(h_eff) + (ROW_BITS+2)'(cy));
    end
    mask_now[3] = ((W_BITS+2)'(out_col) + (W_BITS+2)'(h0) >= (W_BITS+2)'(cx)) &&
                  ((W_BITS+2)'(out_col) + (W_BITS+2)'(h0) <
                   (W_BITS+2)'(w_eff) + (W_BITS+2)'(cx));
    mask_now[4] = ((W_BITS+2)'(out_col) + (W_BITS+2)'(h1) >= (W_BITS+2)'(cx)) &&
                  ((W_BITS+2)'(out_col) + (W_BITS+2)'(h1) <
                   (W_BITS+2)'(w_eff) + (W_BITS+2)'(cx));
    count_now = CNT_BITS'(mask_now[0]) + CNT_BITS'(mask_now[1]) + CNT_BITS'(mask_now[2]) +
                CNT_BITS'(mask_now[3]) + CNT_BITS'(mask_now[4]);
  end

  // Store address of tap k relative to the output pixel's slot.
  always_comb begin
    w_s = $signed(OFF_BITS'(w_eff));
    dv  = $signed({2'b00, k[1:0]}) - $signed({2'b00, cy});
    dh  = $signed({2'b00, (k == K_BITS'(3)) ? h0 : h1}) - $signed({2'b00, cx});
    if (k < K_BITS'(TAPS)) begin
      priority case (dv)
        -4'sd2:  off = -(w_s <<< 1);
        -4'sd1:  off = -w_s;
        4'sd1:   off = w_s;
        4'sd2:   off = w_s <<< 1;
        default: off = '0;
      endcase
    end else begin
      off = OFF_BITS'(dh);
    end
    raw = $signed(OFF_BITS'(oa)) + off;
    if (raw < 0) begin
      raw = raw + OFF_BITS'(SLOTS);
    end else if (raw >= OFF_BITS'(SLOTS)) begin
      raw = raw - OFF_BITS'(SLOTS);
    end
    rd_addr = raw[ADDR_BITS-1:0];
  end

  // Pixel store: write on pixel accept, read one tap per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wa] <= pixel_stream.pixel_rgb;
    end
    if (state == S_READ) begin
      rdata <= store[rd_addr];
    end
  end

  always_comb begin
    lane_ctrl.clear     = accept && emit;
    lane_ctrl.tap_en    = rd_v && mask[rd_k];
    lane_ctrl.is_centre = (rd_k == K_BITS'(cy));
    lane_ctrl.mul_en    = (state == S_MUL);
  end

  for (genvar l = 0; l < CHANNELS; l++) begin : g_lane
    cwif_lane u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .tap    (rdata[l*CHANNEL_BITS +: CHANNEL_BITS]),
      .recip  (recip),
      .limit  (replace_limit),
      .result (lane_res[l*CHANNEL_BITS +: CHANNEL_BITS])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      in_row        <= '0;
      in_col        <= '0;
      out_row       <= '0;
      out_col       <= '0;
      wa            <= '0;
      oa            <= '0;
      lag           <= '0;
      k             <= '0;
      rd_k          <= '0;
      rd_v          <= 1'b0;
      out_valid     <= 1'b0;
      image_width   <= CFG_DIM_BITS'(640);
      image_height  <= CFG_DIM_BITS'(480);
      anchor_x      <= 2'd1;
      anchor_y      <= 2'd1;
      replace_limit <= '0;
    end else begin
      rd_v <= (state == S_READ);
      rd_k <= k;
      if (filtered_stream.valid && filtered_stream.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (wr_en) begin
            // store the pixel and advance the input raster
            wa  <= (wa == ADDR_BITS'(SLOTS - 1)) ? '0 : wa + ADDR_BITS'(1);
            lag <= lag + LAG_BITS'(1);
            if (W_BITS'(in_col) == w_eff - W_BITS'(1)) begin
              in_col <= '0;
              in_row <= in_row + ROW_BITS'(1);
            end else begin
              in_col <= in_col + COL_BITS'(1);
            end
          end
          if (emit) begin
            state <= S_READ;
            k     <= '0;
            mask  <= mask_now;
            recip <= recip_of(count_now);
          end
        end
        S_READ: begin
          k <= k + K_BITS'(1);
          if (k == K_BITS'(TAP_READS - 1)) begin
            state <= S_LAST;
          end
        end
        S_LAST: state <= S_MUL;
        S_MUL:  state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_rgb   <= lane_res;
            out_eof   <= last_out;
            state     <= S_IDLE;
            if (last_out) begin
              // frame done: restart both rasters
              in_row  <= '0;
              in_col  <= '0;
              out_row <= '0;
              out_col <= '0;
              wa      <= '0;
              oa      <= '0;
              lag     <= '0;
            end else begin
              oa  <= (oa == ADDR_BITS'(SLOTS - 1)) ? '0 : oa + ADDR_BITS'(1);
              lag <= lag - LAG_BITS'(1);
              if (W_BITS'(out_col) == w_eff - W_BITS'(1)) begin
                out_col <= '0;
                out_row <= out_row + ROW_BITS'(1);
              end else begin
                out_col <= out_col + COL_BITS'(1);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_wr && (reg_idx <= REG_REPLACE_LIMIT)) begin
        unique case (reg_idx)
          REG_IMAGE_WIDTH:   image_width   <= pwdata[CFG_DIM_BITS-1:0];
          REG_IMAGE_HEIGHT:  image_height  <= pwdata[CFG_DIM_BITS-1:0];
          REG_ANCHOR_X:      anchor_x      <= pwdata[ANCHOR_BITS-1:0];
          REG_ANCHOR_Y:      anchor_y      <= pwdata[ANCHOR_BITS-1:0];
          default:           replace_limit <= $signed(pwdata[LIMIT_BITS-1:0]);
        endcase
        // any register write restarts the frame
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
        wa      <= '0;
        oa      <= '0;
        lag     <= '0;
      end
    end
  end

  assign filtered_stream.valid        = out_valid;
  assign filtered_stream.filtered_rgb = out_rgb;
  assign filtered_stream.end_of_frame = out_eof;

endmodule

FILE: rtl/cwif_checker.sv
// ----------------------------------------------------------------------------
// cwif_checker
// Port-level checks of the cross-window impulse filter, bound to the top.
// ----------------------------------------------------------------------------
module cwif_checker (
  input logic                                  clk,
  input logic                                  rst,
  cwif_in_if.sink                              pixel_stream,
  cwif_out_if.source                           filtered_stream,
  input logic                                  psel,
  input logic                                  penable,
  input logic                                  pwrite,
  input logic [cwif_pkg::APB_ADDR_BITS-1:0]    paddr,
  input logic [cwif_pkg::APB_DATA_BITS-1:0]    pwdata,
  input logic [cwif_pkg::APB_DATA_BITS-1:0]    prdata,
  input logic                                  pready
);
  import cwif_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    filtered_stream.valid && !filtered_stream.ready |=> filtered_stream.valid)
    else $error("result dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !filtered_stream.valid)
    else $error("result shown after reset");

  // a result needs the tap reads: never right after an accepted item
  a_latency: assert property (@(posedge clk) disable iff (rst)
    pixel_stream.valid && pixel_stream.ready |=> !$rose(filtered_stream.valid))
    else $error("result appeared without tap reads");

  a_width_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr[APB_ADDR_BITS-1:2] == REG_IMAGE_WIDTH)
    |=> (!$stable(paddr) || prdata[CFG_DIM_BITS-1:0] == $past(pwdata[CFG_DIM_BITS-1:0])))
    else $error("image_width readback mismatch");

endmodule

bind cross_window_impulse_filter cwif_checker u_cwif_checker (.*);
